// File: rtl/sll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sll_pkg;

  localparam int unsigned SLOTS     = 64;
  localparam int unsigned IDX_W     = $clog2(SLOTS);
  localparam int unsigned POS_W     = 6;
  localparam int unsigned EL_W      = 8;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned MAX_ITEMS = SLOTS - 2;

  localparam logic [IDX_W-1:0] FREE_SLOT = '0;
  localparam logic [IDX_W-1:0] HEAD_SLOT = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_REINIT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             command;
    logic [POS_W-1:0] position;
    logic [EL_W-1:0]  element;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [EL_W-1:0]  element_res;
    logic             has_element;
    logic [CNT_W-1:0] length;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             clr;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
  } link_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [EL_W-1:0]  wdata;
  } data_req_t;

  // Link value of a slot right after reset: free chain in slot order, the
  // last free slot and the head slot both point at the free head.
  function automatic logic [IDX_W-1:0] init_link(input logic [IDX_W-1:0] idx);
    return (idx < IDX_W'(SLOTS - 2)) ? idx + IDX_W'(1) : '0;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sll_link_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module sll_link_mem (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire sll_pkg::link_req_t      req_i,
  output logic [sll_pkg::IDX_W-1:0]    rdata_o
);
  import sll_pkg::*;

  logic [IDX_W-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0] vld_q;
  logic [IDX_W-1:0] rd_q;
  logic [IDX_W-1:0] raddr_q;
  logic             rvld_q;
  logic             fwd;

  // same-cycle write to the read address is forwarded
  assign fwd = req_i.we && (req_i.waddr == req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q    <= fwd ? req_i.wdata : mem_q[req_i.raddr];
    raddr_q <= req_i.raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rvld_q <= !req_i.clr && (fwd || vld_q[req_i.raddr]);
    end
  end

  // entries not written since reset or reinit read as the initial chains
  assign rdata_o = rvld_q ? rd_q : init_link(raddr_q);

endmodule

`default_nettype wire

// File: rtl/sll_data_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sll_data_ram (
  input  wire logic                   clk_i,
  input  wire sll_pkg::data_req_t     req_i,
  output logic [sll_pkg::EL_W-1:0]    rdata_o
);
  import sll_pkg::*;

  logic [EL_W-1:0] mem_q [SLOTS];
  logic [EL_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

// File: rtl/sll_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sll_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire sll_pkg::in_item_t       in_item_i,
  output logic                         in_stall_o,
  input  wire logic                    out_free_i,
  output logic                         res_load_o,
  output sll_pkg::out_item_t           res_o,
  output sll_pkg::link_req_t           link_req_o,
  input  wire logic [sll_pkg::IDX_W-1:0] link_rdata_i,
  output sll_pkg::data_req_t           data_req_o,
  input  wire logic [sll_pkg::EL_W-1:0]  data_rdata_i
);
  import sll_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_J    = 4'd1;
  localparam logic [3:0] S_INS_NJ   = 4'd2;
  localparam logic [3:0] S_WALK     = 4'd3;
  localparam logic [3:0] S_INS_FIX  = 4'd4;
  localparam logic [3:0] S_DEL_J    = 4'd5;
  localparam logic [3:0] S_DEL_F    = 4'd6;
  localparam logic [3:0] S_DEL_H    = 4'd7;
  localparam logic [3:0] S_LST_HEAD = 4'd8;
  localparam logic [3:0] S_LST      = 4'd9;
  localparam logic [3:0] S_RESP     = 4'd10;

  logic [3:0]       state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  logic [EL_W-1:0]  el_q, el_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [POS_W-1:0] steps_q, steps_d;
  logic [CNT_W-1:0] n_q, n_d;
  status_e          stat_q, stat_d;
  logic             accept;
  logic             lst_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign lst_last   = (n_q == count_q - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    el_d    = el_q;
    count_d = count_q;
    k_d     = k_q;
    j_d     = j_q;
    steps_d = steps_q;
    n_d     = n_q;
    stat_d  = stat_q;

    link_req_o = '{clr: 1'b0, raddr: k_q, we: 1'b0, waddr: '0, wdata: '0};
    data_req_o = '{raddr: k_q, we: 1'b0, waddr: '0, wdata: '0};
    res_load_o = 1'b0;
    res_o      = '{status: STAT_OK, element_res: '0, has_element: 1'b0,
                   length: count_q, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        link_req_o.raddr = (in_item_i.command == CMD_DELETE ||
                            in_item_i.command == CMD_LIST) ? HEAD_SLOT : FREE_SLOT;
        if (accept) begin
          cmd_d   = in_item_i.command;
          el_d    = in_item_i.element;
          k_d     = HEAD_SLOT;
          steps_d = in_item_i.position - POS_W'(1);
          n_d     = '0;
          stat_d  = STAT_OK;
          unique case (in_item_i.command)
            CMD_INSERT: begin
              if (in_item_i.position == '0 ||
                  {1'b0, in_item_i.position} > ({1'b0, count_q} + 7'd1)) begin
                stat_d  = STAT_RANGE;
                state_d = S_RESP;
              end else begin
                state_d = S_INS_J;
              end
            end
            CMD_DELETE: begin
              if (in_item_i.position == '0 || in_item_i.position > count_q) begin
                stat_d  = STAT_RANGE;
                state_d = S_RESP;
              end else begin
                state_d = S_WALK;
              end
            end
            CMD_LIST: begin
              state_d = (count_q == '0) ? S_RESP : S_LST_HEAD;
            end
            default: begin
              link_req_o.clr = 1'b1;
              count_d        = '0;
              state_d        = S_RESP;
            end
          endcase
        end
      end

      S_INS_J: begin
        if (link_rdata_i == FREE_SLOT || link_rdata_i == HEAD_SLOT) begin
          stat_d  = STAT_FULL;
          state_d = S_RESP;
        end else begin
          j_d              = link_rdata_i;
          link_req_o.raddr = link_rdata_i;
          data_req_o.we    = 1'b1;
          data_req_o.waddr = link_rdata_i;
          data_req_o.wdata = el_q;
          state_d          = S_INS_NJ;
        end
      end

      S_INS_NJ: begin
        // unhook the taken slot from the free chain, start walk at head
        link_req_o.we    = 1'b1;
        link_req_o.waddr = FREE_SLOT;
        link_req_o.wdata = link_rdata_i;
        link_req_o.raddr = HEAD_SLOT;
        k_d              = HEAD_SLOT;
        state_d          = S_WALK;
      end

      S_WALK: begin
        // link_rdata_i holds the link of slot k_q
        if (steps_q == '0) begin
          if (cmd_q == CMD_INSERT) begin
            link_req_o.we    = 1'b1;
            link_req_o.waddr = j_q;
            link_req_o.wdata = link_rdata_i;
            state_d          = S_INS_FIX;
          end else begin
            j_d              = link_rdata_i;
            link_req_o.raddr = link_rdata_i;
            state_d          = S_DEL_J;
          end
        end else begin
          k_d              = link_rdata_i;
          link_req_o.raddr = link_rdata_i;
          steps_d          = steps_q - POS_W'(1);
        end
      end

      S_INS_FIX: begin
        link_req_o.we    = 1'b1;
        link_req_o.waddr = k_q;
        link_req_o.wdata = j_q;
        count_d          = count_q + CNT_W'(1);
        state_d          = S_RESP;
      end

      S_DEL_J: begin
        link_req_o.we    = 1'b1;
        link_req_o.waddr = k_q;
        link_req_o.wdata = link_rdata_i;
        link_req_o.raddr = FREE_SLOT;
        state_d          = S_DEL_F;
      end

      S_DEL_F: begin
        link_req_o.we    = 1'b1;
        link_req_o.waddr = j_q;
        link_req_o.wdata = link_rdata_i;
        state_d          = S_DEL_H;
      end

      S_DEL_H: begin
        link_req_o.we    = 1'b1;
        link_req_o.waddr = FREE_SLOT;
        link_req_o.wdata = j_q;
        count_d          = count_q - CNT_W'(1);
        state_d          = S_RESP;
      end

      S_LST_HEAD: begin
        k_d              = link_rdata_i;
        link_req_o.raddr = link_rdata_i;
        data_req_o.raddr = link_rdata_i;
        state_d          = S_LST;
      end

      S_LST: begin
        // on a stall the default addresses re-read slot k_q
        if (out_free_i) begin
          res_load_o        = 1'b1;
          res_o.element_res = data_rdata_i;
          res_o.has_element = 1'b1;
          res_o.last        = lst_last;
          if (lst_last) begin
            state_d = S_IDLE;
          end else begin
            k_d              = link_rdata_i;
            link_req_o.raddr = link_rdata_i;
            data_req_o.raddr = link_rdata_i;
            n_d              = n_q + CNT_W'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free_i) begin
          res_load_o   = 1'b1;
          res_o.status = stat_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    el_q    <= el_d;
    k_q     <= k_d;
    j_q     <= j_d;
    steps_q <= steps_d;
    n_q     <= n_d;
    stat_q  <= stat_d;
  end

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |-> out_free_i)
    else $error("result loaded over a held result");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("item count above capacity");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == '0 || count_q == $past(count_q) + CNT_W'(1) ||
       count_q == $past(count_q) - CNT_W'(1)))
    else $error("item count jumped");

endmodule

`default_nettype wire

// File: rtl/static_linked_list_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Linked list of 8-bit elements kept in a 64-slot link memory and data memory.
// Input channel (in_valid_i / in_stall_o, in_item_i) takes one command:
// insert before a 1-based position, delete at a position, list, reinit.
// Output channel (out_valid_o / out_stall_i, out_item_o) returns one result
// per command, or one result per element for a list, last set on the final.
// One command is processed at a time; in_stall_o stays high until its last
// result is loaded into the output register. A list returns one element per
// cycle while the output register is free to take it. The walk along the
// links reads the link memory once a cycle through its single read port.
// Reset (asynchronous, active low) empties the list and rebuilds the free
// chain at once through per-slot valid bits; no clearing pass is needed.
// A held result waits in the output register while out_stall_i is high; a
// list walk pauses on the element in hand until the register frees up.
module static_linked_list_engine_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sll_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sll_pkg::out_item_t      out_item_o
);
  import sll_pkg::*;

  link_req_t        link_req;
  data_req_t        data_req;
  logic [IDX_W-1:0] link_rdata;
  logic [EL_W-1:0]  data_rdata;
  logic             res_load;
  out_item_t        res;
  logic             out_free;
  logic             out_valid_q;
  out_item_t        out_item_q;

  assign out_free = !out_valid_q || !out_stall_i;

  sll_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_stall_o   (in_stall_o),
    .out_free_i   (out_free),
    .res_load_o   (res_load),
    .res_o        (res),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata),
    .data_req_o   (data_req),
    .data_rdata_i (data_rdata)
  );

  sll_link_mem u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  sll_data_ram u_data_ram (
    .clk_i   (clk_i),
    .req_i   (data_req),
    .rdata_o (data_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: tb/tb_static_linked_list_engine_unit.sv
`timescale 1ns / 1ps

module tb_static_linked_list_engine_unit;
  import sll_pkg::*;

  localparam int unsigned RAND_ITEMS     = 134;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 100;

  // Shadow of the slot array; predicts the results of every accepted command.
  class list_scoreboard;
    logic [IDX_W-1:0] link [SLOTS];
    logic [EL_W-1:0]  value [SLOTS];
    int unsigned      count;
    out_item_t        pending [$];
    int unsigned      errors, checked, commands, range_hits, full_hits, max_len;

    function new();
      errors = 0; checked = 0; commands = 0;
      range_hits = 0; full_hits = 0; max_len = 0;
      foreach (value[i]) value[i] = '0;
      rebuild();
    endfunction

    function void rebuild();
      foreach (link[i]) link[i] = (i < SLOTS - 2) ? IDX_W'(i + 1) : '0;
      count = 0;
    endfunction

    function void push(status_e st, logic [EL_W-1:0] el, logic has, logic last);
      out_item_t r;
      r.status      = st;
      r.element_res = el;
      r.has_element = has;
      r.length      = CNT_W'(count);
      r.last        = last;
      pending.push_back(r);
      if (st == STAT_RANGE) range_hits++;
      if (st == STAT_FULL) full_hits++;
    endfunction

    // Slot whose link points at list position pos.
    function logic [IDX_W-1:0] slot_before(int unsigned pos);
      logic [IDX_W-1:0] k;
      k = HEAD_SLOT;
      for (int unsigned l = 1; l < pos; l++) k = link[k];
      return k;
    endfunction

    function void note_input(in_item_t it);
      int unsigned      p;
      logic [IDX_W-1:0] j, k;
      p = it.position;
      commands++;
      case (it.command)
        CMD_INSERT: begin
          if (p == 0 || p > count + 1) begin
            push(STAT_RANGE, '0, 1'b0, 1'b1);
          end else begin
            j = link[FREE_SLOT];
            if (j == FREE_SLOT || j >= HEAD_SLOT) begin
              push(STAT_FULL, '0, 1'b0, 1'b1);
            end else begin
              link[FREE_SLOT] = link[j];
              value[j] = it.element;
              k = slot_before(p);
              link[j] = link[k];
              link[k] = j;
              count++;
              if (count > max_len) max_len = count;
              push(STAT_OK, '0, 1'b0, 1'b1);
            end
          end
        end
        CMD_DELETE: begin
          if (p == 0 || p > count) begin
            push(STAT_RANGE, '0, 1'b0, 1'b1);
          end else begin
            k = slot_before(p);
            j = link[k];
            link[k] = link[j];
            link[j] = link[FREE_SLOT];
            link[FREE_SLOT] = j;
            count--;
            push(STAT_OK, '0, 1'b0, 1'b1);
          end
        end
        CMD_LIST: begin
          if (count == 0) begin
            push(STAT_OK, '0, 1'b0, 1'b1);
          end else begin
            k = link[HEAD_SLOT];
            for (int unsigned n = 0; n < count; n++) begin
              push(STAT_OK, value[k], 1'b1, (n + 1 == count));
              k = link[k];
            end
          end
        end
        default: begin
          rebuild();
          push(STAT_OK, '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.element_res !== want.element_res) begin
        $error("element_res: expected %0d, got %0d", want.element_res, got.element_res);
        errors++;
      end
      if (got.has_element !== want.has_element) begin
        $error("has_element: expected %0d, got %0d", want.has_element, got.has_element);
        errors++;
      end
      if (got.length !== want.length) begin
        $error("length: expected %0d, got %0d", want.length, got.length);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  list_scoreboard sb;
  int unsigned    idle_pct;
  int unsigned    stall_pct;
  bit             hold_go;
  int unsigned    idle_cycles;

  static_linked_list_engine_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_static_linked_list_engine_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t make_cmd(cmd_e c, int unsigned pos, int unsigned el);
    in_item_t it;
    it.command  = c;
    it.position = POS_W'(pos);
    it.element  = EL_W'(el);
    return it;
  endfunction

  // Offer one command; returns right after the edge of its transfer.
  task automatic offer(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  initial begin
    int unsigned r;
    int unsigned extra;
    bit          filling;

    sb = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    hold_go     = 1'b0;
    idle_cycles = 0;
    idle_pct    = 22;
    stall_pct   = 85;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, range errors at both ends, inserts at front,
    // middle and end, deletes, reinit
    offer(make_cmd(CMD_LIST,   0,  8'h00));
    offer(make_cmd(CMD_DELETE, 0,  8'hFF));
    offer(make_cmd(CMD_DELETE, 1,  8'h00));
    offer(make_cmd(CMD_INSERT, 0,  8'h5A));
    offer(make_cmd(CMD_INSERT, 2,  8'hA5));
    offer(make_cmd(CMD_INSERT, 1,  8'h00));
    offer(make_cmd(CMD_INSERT, 2,  8'hFF));
    offer(make_cmd(CMD_INSERT, 1,  8'hA5));
    offer(make_cmd(CMD_INSERT, 2,  8'h3C));
    offer(make_cmd(CMD_LIST,   63, 8'hFF));
    offer(make_cmd(CMD_DELETE, 4,  8'h00));
    offer(make_cmd(CMD_DELETE, 4,  8'h00));
    offer(make_cmd(CMD_DELETE, 1,  8'h00));
    offer(make_cmd(CMD_INSERT, 63, 8'h81));
    offer(make_cmd(CMD_LIST,   0,  8'h00));
    offer(make_cmd(CMD_REINIT, 63, 8'hFF));
    offer(make_cmd(CMD_LIST,   0,  8'h00));
    offer(make_cmd(CMD_DELETE, 63, 8'h7E));
    drain();

    filling = 1'b0;
    extra   = 0;
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        drain();
        idle_pct  = 85;
        stall_pct = 22;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        drain();
        idle_pct  = 0;
        stall_pct = 0;
        // block fills up behind a stalled output while inserts keep coming
        hold_go = 1'b1;
        for (int unsigned n = 0; n < 8; n++)
          offer(make_cmd(CMD_INSERT, $urandom_range(sb.count + 1, 1), $urandom_range(255)));
        drain();
      end
      if (i == 6) filling = 1'b1;

      if (filling) begin
        // grow to a full store, hit it twice, then list everything
        if (sb.count < MAX_ITEMS) begin
          offer(make_cmd(CMD_INSERT, $urandom_range(sb.count + 1, 1), $urandom_range(255)));
        end else if (extra < 2) begin
          offer(make_cmd(CMD_INSERT, (extra == 0) ? 63 : $urandom_range(63, 1),
                         $urandom_range(255)));
          extra++;
        end else begin
          offer(make_cmd(CMD_LIST, $urandom_range(63), $urandom_range(255)));
          filling = 1'b0;
        end
      end else begin
        r = $urandom_range(99);
        if (r < 12)
          offer(make_cmd(cmd_e'($urandom_range(3)), $urandom_range(63), $urandom_range(255)));
        else if (r < 14)
          offer(make_cmd(CMD_REINIT, $urandom_range(63), $urandom_range(255)));
        else if (r < 26)
          offer(make_cmd(CMD_LIST, $urandom_range(63), $urandom_range(255)));
        else if (r < 50 && sb.count > 0)
          offer(make_cmd(CMD_DELETE, $urandom_range(sb.count, 1), $urandom_range(255)));
        else
          offer(make_cmd(CMD_INSERT, $urandom_range(sb.count + 1, 1), $urandom_range(255)));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands, %0d results checked, longest list %0d", sb.commands,
             sb.checked, sb.max_len);
    $display("range errors %0d, full-store rejects %0d, mismatches %0d", sb.range_hits,
             sb.full_hits, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_static_linked_list_engine_unit OK");
    end else begin
      $display("tb_static_linked_list_engine_unit NOT OK");
    end
    $finish;
  end

endmodule
